>>> hdl/hks_pkg.sv
// ----------------------------------------------------------------------------
// hks_pkg
// Types, widths, register indexes and the divider step shared by the
// keyframe sampler and its divider pipeline.
// ----------------------------------------------------------------------------
package hks_pkg;

	localparam int STEP_W        = 10;
	localparam int VAL_W         = 16;
	localparam int CNT_W         = 11;
	localparam int FRAC_W        = 16;
	localparam int DIV_W         = STEP_W + FRAC_W;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = DIV_W / DIV_PER_STAGE;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd2;

	localparam logic [VAL_W-1:0] MIN_RESET    = 16'd0;
	localparam logic [VAL_W-1:0] MAX_RESET    = 16'd256;
	localparam logic [CNT_W-1:0] FRAMES_RESET = 11'd1024;

	typedef struct packed {
		logic [STEP_W-1:0]       step;
		logic [STEP_W-1:0]       seg_length;
		logic [STEP_W-1:0]       start_frame;
		logic signed [VAL_W-1:0] from_value;
		logic signed [VAL_W-1:0] to_value;
		logic signed [VAL_W-1:0] out_tangent;
		logic signed [VAL_W-1:0] out_tangent_mul;
		logic signed [VAL_W-1:0] in_tangent;
		logic signed [VAL_W-1:0] in_tangent_mul;
		logic                    tangents_on;
	} hks_req_t;

	typedef struct packed {
		logic [STEP_W-1:0]       frame_index;
		logic signed [VAL_W-1:0] sample_value;
	} hks_res_t;

	// request fields that ride alongside the divider
	typedef struct packed {
		logic                    herm;
		logic signed [VAL_W-1:0] p1;
		logic signed [VAL_W-1:0] p2;
		logic signed [VAL_W-1:0] ot;
		logic signed [VAL_W-1:0] otm;
		logic signed [VAL_W-1:0] it;
		logic signed [VAL_W-1:0] itm;
	} hks_side_t;

	// one restoring step: returns {quotient bit, new remainder}
	function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] r,
			input logic b, input logic [CNT_W-1:0] d);
		logic [CNT_W:0] x;
		logic [CNT_W:0] dx;
		x  = {r, b};
		dx = {1'b0, d};
		if (x >= dx) begin
			div_step = {1'b1, CNT_W'(x - dx)};
		end else begin
			div_step = {1'b0, x[CNT_W-1:0]};
		end
	endfunction

endpackage

>>> hdl/hks_div.sv
// ----------------------------------------------------------------------------
// hks_div
// Pipelined restoring divider: quotient of num / den and remainder of
// frame / cnt, two bits per stage, with side data carried alongside.
// ----------------------------------------------------------------------------
module hks_div
	import hks_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DIV_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	input  logic [DIV_W-1:0] frame,
	input  logic [CNT_W-1:0] cnt,
	input  hks_side_t        side_in,
	output logic             out_valid,
	output logic [DIV_W-1:0] quot,
	output logic [CNT_W-1:0] frame_mod,
	output hks_side_t        side_out
);

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_W-1:0]      num_s  [DIV_STAGES];
	logic [DIV_W-1:0]      quo_s  [DIV_STAGES];
	logic [DIV_W-1:0]      frm_s  [DIV_STAGES];
	logic [CNT_W-1:0]      rq_s   [DIV_STAGES];
	logic [CNT_W-1:0]      rm_s   [DIV_STAGES];
	logic [CNT_W-1:0]      den_s  [DIV_STAGES];
	logic [CNT_W-1:0]      cnt_s  [DIV_STAGES];
	hks_side_t             side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic             v_in;
		logic [DIV_W-1:0] n_in, q_in, f_in;
		logic [CNT_W-1:0] r_in, m_in, d_in, c_in;
		hks_side_t        sd_in;
		logic [DIV_W-1:0] n_nx, q_nx, f_nx;
		logic [CNT_W-1:0] r_nx, m_nx;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign n_in  = num;
			assign q_in  = '0;
			assign f_in  = frame;
			assign r_in  = '0;
			assign m_in  = '0;
			assign d_in  = den;
			assign c_in  = cnt;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign n_in  = num_s[k-1];
			assign q_in  = quo_s[k-1];
			assign f_in  = frm_s[k-1];
			assign r_in  = rq_s[k-1];
			assign m_in  = rm_s[k-1];
			assign d_in  = den_s[k-1];
			assign c_in  = cnt_s[k-1];
			assign sd_in = side_s[k-1];
		end

		always_comb begin
			logic [DIV_W-1:0] n, q, f;
			logic [CNT_W-1:0] r, m;
			logic [CNT_W:0]   st;
			n = n_in;
			q = q_in;
			f = f_in;
			r = r_in;
			m = m_in;
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				st = div_step(r, n[DIV_W-1], d_in);
				q  = {q[DIV_W-2:0], st[CNT_W]};
				r  = st[CNT_W-1:0];
				n  = {n[DIV_W-2:0], 1'b0};
				st = div_step(m, f[DIV_W-1], c_in);
				m  = st[CNT_W-1:0];
				f  = {f[DIV_W-2:0], 1'b0};
			end
			n_nx = n;
			q_nx = q;
			f_nx = f;
			r_nx = r;
			m_nx = m;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k]  <= n_nx;
			quo_s[k]  <= q_nx;
			frm_s[k]  <= f_nx;
			rq_s[k]   <= r_nx;
			rm_s[k]   <= m_nx;
			den_s[k]  <= d_in;
			cnt_s[k]  <= c_in;
			side_s[k] <= sd_in;
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quot      = quo_s[DIV_STAGES-1];
	assign frame_mod = rm_s[DIV_STAGES-1];
	assign side_out  = side_s[DIV_STAGES-1];

endmodule

>>> hdl/hermite_keyframe_sampler.sv
// ----------------------------------------------------------------------------
// hermite_keyframe_sampler
// Samples one point of a keyframe segment: t = step/length, cubic Hermite
// or linear blend of the key values, clamp, and the table frame index.
//
// channel   signals                              direction  notes
// request   start, busy, request                 in         taken on start && !busy
// config    cfg_valid, cfg_ready, cfg_index,     in         taken on valid && ready
//           cfg_data
// result    result_strobe, result                out        one cycle, no hold-off
//
// One request per clock; busy never rises. A request passes 21 register
// stages: one input stage, 13 divider stages (two quotient bits each) and
// 7 arithmetic stages, the last being the output register. The input stage
// loads on the accepting edge, and the result (if any) strobes when the request
// reaches the output register. Dropped requests simply leave a hole.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module hermite_keyframe_sampler
	import hks_pkg::*;
#(
	parameter int MAX_FRAMES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hks_req_t             request,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	output logic                 result_strobe,
	output hks_res_t             result
);

	logic [VAL_W-1:0] min_q, max_q;
	logic [CNT_W-1:0] frames_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= MIN_RESET;
			max_q    <= MAX_RESET;
			frames_q <= FRAMES_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN:    min_q    <= cfg_data;
				CFG_MAX:    max_q    <= cfg_data;
				CFG_FRAMES: frames_q <= cfg_data[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// input stage
	logic [CNT_W-1:0] eff_cnt;
	logic [CNT_W-1:0] frame_in;
	logic             keep;

	assign eff_cnt  = (32'(frames_q) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : frames_q;
	assign frame_in = CNT_W'(request.start_frame) + CNT_W'(request.step);
	assign keep     = (request.seg_length != '0) && (eff_cnt != '0) &&
		(!request.tangents_on ||
		 ((request.step <= request.seg_length) && (frame_in < eff_cnt)));

	logic              vld_s1;
	logic [STEP_W-1:0] step_s1, len_s1;
	logic [CNT_W-1:0]  frame_s1, cnt_s1;
	hks_side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy && keep;
		end
	end

	always_ff @(posedge clk) begin
		step_s1      <= request.step;
		len_s1       <= request.seg_length;
		frame_s1     <= frame_in;
		cnt_s1       <= eff_cnt;
		side_s1.herm <= request.tangents_on;
		side_s1.p1   <= request.from_value;
		side_s1.p2   <= request.to_value;
		side_s1.ot   <= request.out_tangent;
		side_s1.otm  <= request.out_tangent_mul;
		side_s1.it   <= request.in_tangent;
		side_s1.itm  <= request.in_tangent_mul;
	end

	// divider: t and frame modulo count
	logic             dv;
	logic [DIV_W-1:0] dq;
	logic [CNT_W-1:0] dm;
	hks_side_t        dside;

	hks_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.num       ({step_s1, FRAC_W'(0)}),
		.den       (CNT_W'(len_s1)),
		.frame     (DIV_W'(frame_s1)),
		.cnt       (cnt_s1),
		.side_in   (side_s1),
		.out_valid (dv),
		.quot      (dq),
		.frame_mod (dm),
		.side_out  (dside)
	);

	// s3: t squared, tangents, linear product
	logic signed [16:0] diff_c;
	assign diff_c = 17'(dside.p2) - 17'(dside.p1);

	logic                    vld_s3, herm_s3;
	logic [16:0]             t17_s3;
	logic [33:0]             t2_s3;
	logic signed [32:0]      m1_s3, m2_s3;
	logic signed [43:0]      lind_s3;
	logic signed [VAL_W-1:0] p1_s3, p2_s3;
	logic [STEP_W-1:0]       frm_s3;

	always_ff @(posedge clk) begin
		herm_s3 <= dside.herm;
		t17_s3  <= dq[16:0];
		t2_s3   <= 34'(dq[16:0]) * 34'(dq[16:0]);
		m1_s3   <= -(33'(dside.ot) * 33'(dside.otm));
		m2_s3   <= 33'(dside.it) * 33'(dside.itm);
		lind_s3 <= 44'(diff_c) * 44'($signed({1'b0, dq}));
		p1_s3   <= dside.p1;
		p2_s3   <= dside.p2;
		frm_s3  <= dm[STEP_W-1:0];
	end

	// s4: t cubed, linear value
	logic                    vld_s4, herm_s4;
	logic [16:0]             t17_s4;
	logic [33:0]             t2_s4, t3_s4;
	logic signed [32:0]      m1_s4, m2_s4;
	logic signed [28:0]      linv_s4;
	logic signed [VAL_W-1:0] p1_s4, p2_s4;
	logic [STEP_W-1:0]       frm_s4;

	always_ff @(posedge clk) begin
		herm_s4 <= herm_s3;
		t17_s4  <= t17_s3;
		t2_s4   <= t2_s3;
		t3_s4   <= 34'((50'(t2_s3) * 50'(t17_s3) + 50'd32768) >> 16);
		m1_s4   <= m1_s3;
		m2_s4   <= m2_s3;
		linv_s4 <= 29'(p1_s3) + 29'((lind_s3 + 44'sd32768) >>> 16);
		p1_s4   <= p1_s3;
		p2_s4   <= p2_s3;
		frm_s4  <= frm_s3;
	end

	// s5: Hermite basis
	logic signed [36:0] t2x, t3x, tx, e_c;
	assign t2x = $signed({3'b000, t2_s4});
	assign t3x = $signed({3'b000, t3_s4});
	assign tx  = $signed(37'({t17_s4, 16'h0000}));
	assign e_c = 37'sd3 * t2x - 37'sd2 * t3x;

	logic                    vld_s5, herm_s5;
	logic signed [36:0]      h00_s5, h01_s5;
	logic signed [32:0]      h10_s5, h11_s5;
	logic signed [32:0]      m1_s5, m2_s5;
	logic signed [28:0]      linv_s5;
	logic signed [VAL_W-1:0] p1_s5, p2_s5;
	logic [STEP_W-1:0]       frm_s5;

	always_ff @(posedge clk) begin
		herm_s5 <= herm_s4;
		h00_s5  <= (37'sd1 <<< 32) - e_c;
		h01_s5  <= e_c;
		h10_s5  <= 33'(tx - 37'sd2 * t2x + t3x);
		h11_s5  <= 33'(t3x - t2x);
		m1_s5   <= m1_s4;
		m2_s5   <= m2_s4;
		linv_s5 <= linv_s4;
		p1_s5   <= p1_s4;
		p2_s5   <= p2_s4;
		frm_s5  <= frm_s4;
	end

	// s6: basis times keys and tangents
	logic               vld_s6, herm_s6;
	logic signed [52:0] ph00_s6, ph01_s6;
	logic signed [65:0] ph10_s6, ph11_s6;
	logic signed [28:0] linv_s6;
	logic [STEP_W-1:0]  frm_s6;

	always_ff @(posedge clk) begin
		herm_s6 <= herm_s5;
		ph00_s6 <= 53'(h00_s5) * 53'(p1_s5);
		ph01_s6 <= 53'(h01_s5) * 53'(p2_s5);
		ph10_s6 <= 66'(h10_s5) * 66'(m1_s5);
		ph11_s6 <= 66'(h11_s5) * 66'(m2_s5);
		linv_s6 <= linv_s5;
		frm_s6  <= frm_s5;
	end

	// s7: sum in Q52
	logic               vld_s7, herm_s7;
	logic signed [65:0] sum_s7;
	logic signed [28:0] linv_s7;
	logic [STEP_W-1:0]  frm_s7;

	always_ff @(posedge clk) begin
		herm_s7 <= herm_s6;
		sum_s7  <= ((66'(ph00_s6) + 66'(ph01_s6)) <<< 12) + ph10_s6 + ph11_s6;
		linv_s7 <= linv_s6;
		frm_s7  <= frm_s6;
	end

	// s8: round to Q8.8 and pick the mode
	logic               vld_s8;
	logic signed [28:0] v_s8;
	logic [STEP_W-1:0]  frm_s8;

	always_ff @(posedge clk) begin
		v_s8   <= herm_s7 ? 29'((sum_s7 + (66'sd1 <<< 43)) >>> 44) : linv_s7;
		frm_s8 <= frm_s7;
	end

	// s9: clamp into the output register
	logic signed [28:0] lo_c, hi_c, c1, c2;
	assign lo_c = 29'($signed(min_q));
	assign hi_c = 29'($signed(max_q));
	assign c1   = (v_s8 < lo_c) ? lo_c : v_s8;
	assign c2   = (c1 > hi_c) ? hi_c : c1;

	logic     vld_s9;
	hks_res_t res_s9;

	always_ff @(posedge clk) begin
		res_s9.frame_index  <= frm_s8;
		res_s9.sample_value <= VAL_W'(c2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s3 <= dv;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	assign result_strobe = vld_s9;
	assign result        = res_s9;

	// clamp never lets a result above the upper bound through
	a_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 |-> $signed(res_s9.sample_value) <= $signed($past(max_q)))
		else $error("result above upper clamp");

	// a result under the lower bound can only come from max overriding min
	a_min_order: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s9 && ($signed(res_s9.sample_value) < $signed($past(min_q))))
		|-> (res_s9.sample_value == $past(max_q)))
		else $error("lower clamp not applied");

	// hermite requests have step within length, so t never exceeds one
	a_herm_t: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && herm_s3) |-> (t2_s3 <= 34'h1_0000_0000))
		else $error("hermite t above one");

	// a valid request leaves the divider after passing through all DIV_STAGES stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ##(DIV_STAGES) dv)
		else $error("divider lost a request");

endmodule
